>>> rtl/tlc_pkg.sv
// Shared constants, types and defaults for the two-level cache tag block.
package tlc_pkg;

  // Fixed field widths
  localparam int unsigned AddrW   = 48;
  localparam int unsigned LatW    = 8;
  localparam int unsigned SumW    = 9;
  localparam int unsigned InDataW = 48;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  // Parameter defaults
  localparam int unsigned FirstSetsDef   = 64;
  localparam int unsigned FirstWaysDef   = 8;
  localparam int unsigned SecondSetsDef  = 1024;
  localparam int unsigned SecondWaysDef  = 16;
  localparam int unsigned LineOffsetDef  = 6;
  localparam int unsigned AddressBitsDef = 48;

  // Register reset values
  localparam logic [LatW-1:0] FirstLatRst  = 8'd4;
  localparam logic [LatW-1:0] SecondLatRst = 8'd12;

  // Register byte addresses
  localparam logic [ApbAddrW-1:0] RegFirstEn   = 4'h0;
  localparam logic [ApbAddrW-1:0] RegSecondEn  = 4'h4;
  localparam logic [ApbAddrW-1:0] RegFirstLat  = 4'h8;
  localparam logic [ApbAddrW-1:0] RegSecondLat = 4'hC;

  // Command codes
  localparam logic CmdLookup = 1'b0;
  localparam logic CmdFill   = 1'b1;

  // Hit level codes
  localparam logic [1:0] LvlNone   = 2'd0;
  localparam logic [1:0] LvlFirst  = 2'd1;
  localparam logic [1:0] LvlSecond = 2'd2;

  // Status of one pass of the replacement unit
  typedef struct packed {
    logic hit;  // tag found among valid ways
    logic wr;   // row changed, write it back
  } lru_res_t;

endpackage

>>> rtl/tlc_lru_unit.sv
// Shared tag compare and true-LRU update unit for one cache set row.
module tlc_lru_unit #(
  parameter int unsigned MW = 16,
  parameter int unsigned TW = 36,
  parameter int unsigned AW = 4,
  localparam int unsigned NwW = $clog2(MW + 1),
  localparam int unsigned IW  = (MW > 1) ? $clog2(MW) : 1
) (
  input  logic [NwW-1:0]         nways_i,
  input  logic                   insert_i,
  input  logic [TW-1:0]          tag_i,
  input  logic [MW-1:0][TW-1:0]  tags_i,
  input  logic [MW-1:0]          valid_i,
  input  logic [MW-1:0][AW-1:0]  age_i,
  output logic [MW-1:0][TW-1:0]  tags_o,
  output logic [MW-1:0]          valid_o,
  output logic [MW-1:0][AW-1:0]  age_o,
  output tlc_pkg::lru_res_t      res_o
);

  logic           found, any_free, touch;
  logic [IW-1:0]  fw, ffw, vw, w;
  logic [NwW-1:0] old;

  // Search: matching way, lowest free way, least recent way
  always_comb begin
    found    = 1'b0;
    any_free = 1'b0;
    fw       = '0;
    ffw      = '0;
    vw       = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (NwW'(i) < nways_i) begin
        if (valid_i[i] && tags_i[i] == tag_i) begin
          found = 1'b1;
          fw    = IW'(i);
        end
        if (!valid_i[i]) begin
          any_free = 1'b1;
          ffw      = IW'(i);
        end
        if (valid_i[i] && NwW'(age_i[i]) == nways_i - NwW'(1)) begin
          vw = IW'(i);
        end
      end
    end
  end

  // Pick the way to touch and its previous rank
  always_comb begin
    touch = found || insert_i;
    if (found) begin
      w   = fw;
      old = NwW'(age_i[fw]);
    end else if (any_free) begin
      w   = ffw;
      old = nways_i;
    end else begin
      w   = vw;
      old = nways_i;
    end
  end

  // Age every younger valid way, make the touched way most recent
  always_comb begin
    tags_o  = tags_i;
    valid_o = valid_i;
    age_o   = age_i;
    if (touch) begin
      for (int i = 0; i < MW; i++) begin
        if (IW'(i) != w && valid_i[i] && NwW'(age_i[i]) < old) begin
          age_o[i] = age_i[i] + AW'(1);
        end
      end
      age_o[w]   = '0;
      valid_o[w] = 1'b1;
      if (!found) begin
        tags_o[w] = tag_i;
      end
    end
  end

  assign res_o.hit = found;
  assign res_o.wr  = touch;

endmodule

>>> rtl/two_level_lru_cache_tags.sv
// Top level: two-level set-associative tag store with true LRU and APB config.
//
//  channel   | dir | handshake        | payload
//  s_axis    | in  | tvalid/tready    | tdata: address; tuser: command
//  m_axis    | out | tvalid/tready    | tdata: hit, hit_level, latency
//  apb       | in  | psel/penable     | 4 registers at 0x0..0xC
//
// Lookup states: a level one hit runs L1, DONE; a level two hit L1, L2, FILL1,
// DONE; a miss L1, L2, DONE; a fill L1, FILL1, DONE. L1, L2 and FILL1 each do
// one row read-modify-write through the shared LRU unit. After reset a clearing
// pass over every row index zeroes valid and age rows; no word is taken then.
// A waiting result holds the block in its last state until taken.
module two_level_lru_cache_tags #(
  parameter int unsigned FIRST_SETS       = tlc_pkg::FirstSetsDef,
  parameter int unsigned FIRST_WAYS       = tlc_pkg::FirstWaysDef,
  parameter int unsigned SECOND_SETS      = tlc_pkg::SecondSetsDef,
  parameter int unsigned SECOND_WAYS      = tlc_pkg::SecondWaysDef,
  parameter int unsigned LINE_OFFSET_BITS = tlc_pkg::LineOffsetDef,
  parameter int unsigned ADDRESS_BITS     = tlc_pkg::AddressBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [tlc_pkg::InDataW-1:0]   s_axis_tdata_i,  // [47:0] address
  input  logic                          s_axis_tuser_i,  // [0] command
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [tlc_pkg::OutDataW-1:0]  m_axis_tdata_o,  // [0] hit, [2:1] hit_level,
                                                         // [11:3] latency, [15:12] zero
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [tlc_pkg::ApbAddrW-1:0]  paddr_i,
  input  logic [tlc_pkg::ApbDataW-1:0]  pwdata_i,
  output logic [tlc_pkg::ApbDataW-1:0]  prdata_o,
  output logic                          pready_o
);

  localparam int unsigned ABits = (ADDRESS_BITS < tlc_pkg::AddrW) ? ADDRESS_BITS : tlc_pkg::AddrW;
  localparam int unsigned Idx1W  = $clog2(FIRST_SETS + 1) - 1;
  localparam int unsigned Idx2W  = $clog2(SECOND_SETS + 1) - 1;
  localparam int unsigned Idx1AW = (Idx1W > 0) ? Idx1W : 1;
  localparam int unsigned Idx2AW = (Idx2W > 0) ? Idx2W : 1;
  localparam int unsigned Rows1  = 1 << Idx1AW;
  localparam int unsigned Rows2  = 1 << Idx2AW;
  localparam int unsigned Tag1W  = ABits - LINE_OFFSET_BITS - Idx1W;
  localparam int unsigned Tag2W  = ABits - LINE_OFFSET_BITS - Idx2W;
  localparam int unsigned Age1W  = (FIRST_WAYS > 1) ? $clog2(FIRST_WAYS) : 1;
  localparam int unsigned Age2W  = (SECOND_WAYS > 1) ? $clog2(SECOND_WAYS) : 1;
  localparam int unsigned MW     = (FIRST_WAYS > SECOND_WAYS) ? FIRST_WAYS : SECOND_WAYS;
  localparam int unsigned TW     = (Tag1W > Tag2W) ? Tag1W : Tag2W;
  localparam int unsigned AW     = (Age1W > Age2W) ? Age1W : Age2W;
  localparam int unsigned NwW    = $clog2(MW + 1);
  localparam int unsigned ClrW   = (Idx1AW > Idx2AW) ? Idx1AW : Idx2AW;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_L1, ST_L2, ST_FILL1, ST_DONE
  } state_e;

  // Config registers
  logic                     en1_q, en2_q;
  logic [tlc_pkg::LatW-1:0] lat1_q, lat2_q;

  // Control and payload registers
  state_e               state_q;
  logic [ClrW-1:0]      clr_q;
  logic                 cmd_q;
  logic [Idx1AW-1:0]    set1_q;
  logic [Idx2AW-1:0]    set2_q;
  logic [Tag1W-1:0]     tag1_q;
  logic [Tag2W-1:0]     tag2_q;
  logic                 hit_q;
  logic [1:0]           lvl_q;
  logic [tlc_pkg::SumW-1:0] lat_q;
  logic                 mvalid_q;
  logic [tlc_pkg::OutDataW-1:0] mdata_q;

  // Row memories
  logic [FIRST_WAYS-1:0][Tag1W-1:0]  tag1_mem [Rows1];
  logic [FIRST_WAYS-1:0]             val1_mem [Rows1];
  logic [FIRST_WAYS-1:0][Age1W-1:0]  age1_mem [Rows1];
  logic [SECOND_WAYS-1:0][Tag2W-1:0] tag2_mem [Rows2];
  logic [SECOND_WAYS-1:0]            val2_mem [Rows2];
  logic [SECOND_WAYS-1:0][Age2W-1:0] age2_mem [Rows2];
  logic [FIRST_WAYS-1:0][Tag1W-1:0]  tag1_rd_q;
  logic [FIRST_WAYS-1:0]             val1_rd_q;
  logic [FIRST_WAYS-1:0][Age1W-1:0]  age1_rd_q;
  logic [SECOND_WAYS-1:0][Tag2W-1:0] tag2_rd_q;
  logic [SECOND_WAYS-1:0]            val2_rd_q;
  logic [SECOND_WAYS-1:0][Age2W-1:0] age2_rd_q;

  // Address split
  logic [tlc_pkg::AddrW-1:0] addr_m, sh1, sh2;
  logic [Idx1AW-1:0]         set1;
  logic [Idx2AW-1:0]         set2;

  always_comb begin
    addr_m = s_axis_tdata_i & ((tlc_pkg::AddrW'(1) << ABits) - tlc_pkg::AddrW'(1));
    if (ABits == tlc_pkg::AddrW) addr_m = s_axis_tdata_i;
    sh1 = addr_m >> (LINE_OFFSET_BITS + Idx1W);
    sh2 = addr_m >> (LINE_OFFSET_BITS + Idx2W);
    set1 = (Idx1W > 0) ? Idx1AW'(addr_m >> LINE_OFFSET_BITS) : '0;
    set2 = (Idx2W > 0) ? Idx2AW'(addr_m >> LINE_OFFSET_BITS) : '0;
  end

  logic accept;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Shared unit operand select
  logic                 use2, ins, lvl_en;
  logic [NwW-1:0]       nways;
  logic [TW-1:0]        u_tag;
  logic [MW-1:0][TW-1:0] u_tags_in, u_tags_out;
  logic [MW-1:0]         u_val_in, u_val_out;
  logic [MW-1:0][AW-1:0] u_age_in, u_age_out;
  tlc_pkg::lru_res_t     u_res;

  always_comb begin
    use2 = (state_q == ST_L2) || (state_q == ST_L1 && cmd_q == tlc_pkg::CmdFill);
    ins  = (state_q == ST_FILL1) || (state_q == ST_L1 && cmd_q == tlc_pkg::CmdFill);
    lvl_en    = use2 ? en2_q : en1_q;
    nways     = use2 ? NwW'(SECOND_WAYS) : NwW'(FIRST_WAYS);
    u_tag     = use2 ? TW'(tag2_q) : TW'(tag1_q);
    u_tags_in = '0;
    u_val_in  = '0;
    u_age_in  = '0;
    if (use2) begin
      for (int i = 0; i < SECOND_WAYS; i++) begin
        u_tags_in[i] = TW'(tag2_rd_q[i]);
        u_val_in[i]  = val2_rd_q[i];
        u_age_in[i]  = AW'(age2_rd_q[i]);
      end
    end else begin
      for (int i = 0; i < FIRST_WAYS; i++) begin
        u_tags_in[i] = TW'(tag1_rd_q[i]);
        u_val_in[i]  = val1_rd_q[i];
        u_age_in[i]  = AW'(age1_rd_q[i]);
      end
    end
  end

  tlc_lru_unit #(.MW(MW), .TW(TW), .AW(AW)) u_lru (
    .nways_i  (nways),
    .insert_i (ins),
    .tag_i    (u_tag),
    .tags_i   (u_tags_in),
    .valid_i  (u_val_in),
    .age_i    (u_age_in),
    .tags_o   (u_tags_out),
    .valid_o  (u_val_out),
    .age_o    (u_age_out),
    .res_o    (u_res)
  );

  logic busy1, busy2, hit_u;
  assign busy1 = (state_q == ST_FILL1) || (state_q == ST_L1 && cmd_q == tlc_pkg::CmdLookup);
  assign busy2 = use2;
  assign hit_u = lvl_en && u_res.hit;

  // Write-back select
  logic                              we1, we2;
  logic [Idx1AW-1:0]                 wa1;
  logic [Idx2AW-1:0]                 wa2;
  logic [FIRST_WAYS-1:0][Tag1W-1:0]  wt1;
  logic [FIRST_WAYS-1:0]             wv1;
  logic [FIRST_WAYS-1:0][Age1W-1:0]  wg1;
  logic [SECOND_WAYS-1:0][Tag2W-1:0] wt2;
  logic [SECOND_WAYS-1:0]            wv2;
  logic [SECOND_WAYS-1:0][Age2W-1:0] wg2;

  always_comb begin
    we1 = (state_q == ST_CLEAR) || (busy1 && en1_q && u_res.wr);
    we2 = (state_q == ST_CLEAR) || (busy2 && en2_q && u_res.wr);
    wa1 = (state_q == ST_CLEAR) ? Idx1AW'(clr_q) : set1_q;
    wa2 = (state_q == ST_CLEAR) ? Idx2AW'(clr_q) : set2_q;
    wt1 = '0; wv1 = '0; wg1 = '0;
    wt2 = '0; wv2 = '0; wg2 = '0;
    if (state_q != ST_CLEAR) begin
      for (int i = 0; i < FIRST_WAYS; i++) begin
        wt1[i] = Tag1W'(u_tags_out[i]);
        wv1[i] = u_val_out[i];
        wg1[i] = Age1W'(u_age_out[i]);
      end
      for (int i = 0; i < SECOND_WAYS; i++) begin
        wt2[i] = Tag2W'(u_tags_out[i]);
        wv2[i] = u_val_out[i];
        wg2[i] = Age2W'(u_age_out[i]);
      end
    end
  end

  // Level one memory
  always_ff @(posedge clk_i) begin
    if (we1) begin
      tag1_mem[wa1] <= wt1;
      val1_mem[wa1] <= wv1;
      age1_mem[wa1] <= wg1;
    end
    if (accept) begin
      tag1_rd_q <= tag1_mem[set1];
      val1_rd_q <= val1_mem[set1];
      age1_rd_q <= age1_mem[set1];
    end
  end

  // Level two memory
  always_ff @(posedge clk_i) begin
    if (we2) begin
      tag2_mem[wa2] <= wt2;
      val2_mem[wa2] <= wv2;
      age2_mem[wa2] <= wg2;
    end
    if (accept) begin
      tag2_rd_q <= tag2_mem[set2];
      val2_rd_q <= val2_mem[set2];
      age2_rd_q <= age2_mem[set2];
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      mvalid_q <= 1'b0;
    end else begin
      if (mvalid_q && m_axis_tready_i) mvalid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + ClrW'(1);
          if (&clr_q) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) state_q <= ST_L1;
        end
        ST_L1: begin
          if (cmd_q == tlc_pkg::CmdFill) state_q <= ST_FILL1;
          else if (hit_u)                state_q <= ST_DONE;
          else                           state_q <= ST_L2;
        end
        ST_L2: begin
          state_q <= hit_u ? ST_FILL1 : ST_DONE;
        end
        ST_FILL1: state_q <= ST_DONE;
        ST_DONE: begin
          if (!mvalid_q || m_axis_tready_i) begin
            mvalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Item payload and result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tuser_i;
      set1_q <= set1;
      set2_q <= set2;
      tag1_q <= Tag1W'(sh1);
      tag2_q <= Tag2W'(sh2);
    end
    if (state_q == ST_L1) begin
      if (cmd_q == tlc_pkg::CmdFill) begin
        hit_q <= 1'b0; lvl_q <= tlc_pkg::LvlNone; lat_q <= '0;
      end else if (hit_u) begin
        hit_q <= 1'b1; lvl_q <= tlc_pkg::LvlFirst;
        lat_q <= tlc_pkg::SumW'(lat1_q);
      end else begin
        hit_q <= 1'b0; lvl_q <= tlc_pkg::LvlNone;
        lat_q <= tlc_pkg::SumW'(lat1_q) + tlc_pkg::SumW'(lat2_q);
      end
    end
    if (state_q == ST_L2 && hit_u) begin
      hit_q <= 1'b1; lvl_q <= tlc_pkg::LvlSecond;
    end
    if (state_q == ST_DONE && (!mvalid_q || m_axis_tready_i)) begin
      mdata_q <= {4'b0000, lat_q, lvl_q, hit_q};
    end
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;

  // APB register file
  logic cfg_we;
  assign cfg_we   = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en1_q  <= 1'b1;
      en2_q  <= 1'b1;
      lat1_q <= tlc_pkg::FirstLatRst;
      lat2_q <= tlc_pkg::SecondLatRst;
    end else if (cfg_we) begin
      priority case (paddr_i)
        tlc_pkg::RegFirstEn:   en1_q  <= pwdata_i[0];
        tlc_pkg::RegSecondEn:  en2_q  <= pwdata_i[0];
        tlc_pkg::RegFirstLat:  lat1_q <= pwdata_i[tlc_pkg::LatW-1:0];
        tlc_pkg::RegSecondLat: lat2_q <= pwdata_i[tlc_pkg::LatW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority case (paddr_i)
      tlc_pkg::RegFirstEn:   prdata_o = tlc_pkg::ApbDataW'(en1_q);
      tlc_pkg::RegSecondEn:  prdata_o = tlc_pkg::ApbDataW'(en2_q);
      tlc_pkg::RegFirstLat:  prdata_o = tlc_pkg::ApbDataW'(lat1_q);
      tlc_pkg::RegSecondLat: prdata_o = tlc_pkg::ApbDataW'(lat2_q);
      default:               prdata_o = '0;
    endcase
  end

endmodule

>>> rtl/tlc_checker.sv
// Port-level checker for the cache tag block, bound to the top level.
module tlc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [tlc_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  // Hit flag agrees with the reported level
  a_hit_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[0] == (m_axis_tdata_o[2:1] != tlc_pkg::LvlNone)))
    else $error("hit flag and hit level disagree");

  // Level code three never appears
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[2:1] != 2'd3))
    else $error("bad hit level");

  // An accepted word makes the block busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready right after accept");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result dropped under stall");

endmodule

bind two_level_lru_cache_tags tlc_checker u_tlc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
